[rtl/core/pba_pkg.sv]
// ----------------------------------------------------------------------------
// Page bitmap allocator package
// Shared widths, register indexes, request codes and the controller state
// type for the page bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pba_pkg;

   // Default sizing of the bitmap.
   localparam int NUM_PAGES_DEF = 4096;
   localparam int WORD_BITS_DEF = 64;

   // Field widths of the request, response and register ports.
   localparam int BASE_W      = 12;
   localparam int COUNT_W     = 13;
   localparam int PAGE_W      = 12;
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 2;

   // Width of page positions during a search. It holds a start page plus a
   // stride or a run length taken from the request fields.
   localparam int POS_W = 15;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_PAGE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAGES_IN_USE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRACK_FREE   = 2'd2;

   // Register reset values.
   localparam logic [BASE_W-1:0]  BASE_PAGE_RST    = 12'd0;
   localparam logic [COUNT_W-1:0] PAGES_IN_USE_RST = 13'd4096;
   localparam logic               TRACK_FREE_RST   = 1'b1;

   // Request codes.
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // Controller states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ALLOC_INIT,
      ST_CHK_RD,
      ST_CHK_EVAL,
      ST_FREE_INIT,
      ST_SET_RD,
      ST_SET_WR
   } state_type;

endpackage

`default_nettype wire

[rtl/core/pba_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered. No reset on the
// storage.
// ----------------------------------------------------------------------------
`default_nettype none

module pba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/page_bitmap_allocator.sv]
// ----------------------------------------------------------------------------
// Page bitmap allocator
// First-fit allocator of contiguous page runs over a bitmap of used pages.
// ----------------------------------------------------------------------------
// The bitmap lives in one RAM of WORD_BITS-bit words, one bit per page, and
// every request is a read-modify-write walk over it, word by word (read,
// then check or write back). After reset the block sets every page to used,
// one word at a time, and holds busy high meanwhile; configuration writes are
// taken at any time. A free request passes an init step, then a read and a
// write-back step per bitmap word it touches. An allocate request judges each
// candidate start page in turn, reads and checks each bitmap word of its run,
// then reads and writes back each word marked used for the winning run. The
// response appears on the cycle after the last step with rsp_valid high for
// exactly one cycle, and the receiver cannot stall it; busy is already low
// during that cycle, so a new transaction may be started there.
// WORD_BITS must be a power of two.
// ----------------------------------------------------------------------------
`default_nettype none

module page_bitmap_allocator #(
   parameter int NUM_PAGES = pba_pkg::NUM_PAGES_DEF,
   parameter int WORD_BITS = pba_pkg::WORD_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Request channel
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic                            req_type,
   input  wire logic [pba_pkg::COUNT_W-1:0]     req_page_count,
   input  wire logic [pba_pkg::COUNT_W-1:0]     req_step_pages,
   input  wire logic [pba_pkg::COUNT_W-1:0]     req_limit_page,
   input  wire logic [pba_pkg::PAGE_W-1:0]      req_page_index,
   // Response channel
   output logic                                 rsp_valid,
   output logic                                 rsp_ok,
   output logic      [pba_pkg::PAGE_W-1:0]      rsp_result_page,
   output logic      [pba_pkg::COUNT_W-1:0]     rsp_free_count,
   // Configuration port
   input  wire logic                            csr_write_enable,
   input  wire logic [pba_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [pba_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   localparam int NUM_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int OFF_W     = $clog2(WORD_BITS);
   localparam int CNT_W     = $clog2(NUM_PAGES + 1);
   localparam int SUM_W     = ((CNT_W > pba_pkg::COUNT_W) ? CNT_W : pba_pkg::COUNT_W) + 1;
   localparam int POS_W     = pba_pkg::POS_W;
   localparam int COUNT_W   = pba_pkg::COUNT_W;
   localparam int PAGE_W    = pba_pkg::PAGE_W;

   // Configuration registers
   logic [pba_pkg::BASE_W-1:0] base_ff;
   logic [COUNT_W-1:0]         piu_ff;
   logic                       track_ff;

   // Controller registers
   pba_pkg::state_type state_ff, state_in;
   logic               type_ff, type_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] step_ff, step_in;
   logic [COUNT_W-1:0] max_ff, max_in;
   logic [POS_W-1:0]   idx_ff, idx_in;
   logic [POS_W-1:0]   s_ff, s_in;
   logic [POS_W-1:0]   e_ff, e_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   // Response registers
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_ok_ff, rsp_ok_in;
   logic [PAGE_W-1:0]   rsp_page_ff, rsp_page_in;

   // Bitmap RAM interface
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic [AW-1:0]        word_addr;
   logic [WORD_BITS-1:0] rd_data;

   // Datapath helpers
   logic [COUNT_W-1:0]   cov;
   logic [POS_W-1:0]     free_end;
   logic [POS_W-1:0]     word_base;
   logic [POS_W-1:0]     next_s;
   logic [POS_W-1:0]     rem;
   logic [OFF_W-1:0]     lo;
   logic [WORD_BITS-1:0] mask;
   logic                 word_last;
   logic                 word_busy;
   logic [POS_W-1:0]     idx_step;
   logic [SUM_W-1:0]     sum_free;
   logic [CNT_W-1:0]     cnt_free;
   logic [CNT_W-1:0]     cnt_alloc;

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= pba_pkg::BASE_PAGE_RST;
         piu_ff   <= pba_pkg::PAGES_IN_USE_RST;
         track_ff <= pba_pkg::TRACK_FREE_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            pba_pkg::CSR_BASE_PAGE: begin
               base_ff <= csr_write_data[pba_pkg::BASE_W-1:0];
            end
            pba_pkg::CSR_PAGES_IN_USE: begin
               piu_ff <= csr_write_data[COUNT_W-1:0];
            end
            pba_pkg::CSR_TRACK_FREE: begin
               track_ff <= csr_write_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Coverage is the number of pages in use, clipped to the bitmap size.
   assign cov = (SUM_W'(piu_ff) > SUM_W'(NUM_PAGES)) ? COUNT_W'(NUM_PAGES) : piu_ff;

   // End of a free run, clipped to the coverage.
   always_comb begin
      free_end = POS_W'(req_page_index) + POS_W'(req_page_count);
      if (free_end > POS_W'(cov)) begin
         free_end = POS_W'(cov);
      end
   end

   // Word-level view of the current position: the word address, the mask of
   // bits between the position and the end of the run, and the next word.
   assign word_addr = AW'(s_ff >> OFF_W);
   assign word_base = (s_ff >> OFF_W) << OFF_W;
   assign lo        = s_ff[OFF_W-1:0];
   assign rem       = e_ff - word_base;
   assign next_s    = word_base + POS_W'(WORD_BITS);
   assign word_last = (next_s >= e_ff);
   assign idx_step  = idx_ff + POS_W'(step_ff);

   always_comb begin
      for (int j = 0; j < WORD_BITS; j++) begin
         mask[j] = (OFF_W'(j) >= lo) && (POS_W'(j) < rem);
      end
   end

   assign word_busy = |(rd_data & mask);

   // Free page counter updates, saturating at zero and at the bitmap size.
   always_comb begin
      sum_free = SUM_W'(cnt_ff) + SUM_W'(count_ff);
      if (sum_free > SUM_W'(NUM_PAGES)) begin
         cnt_free = CNT_W'(NUM_PAGES);
      end else begin
         cnt_free = CNT_W'(sum_free);
      end
      if (SUM_W'(cnt_ff) > SUM_W'(count_ff)) begin
         cnt_alloc = CNT_W'(SUM_W'(cnt_ff) - SUM_W'(count_ff));
      end else begin
         cnt_alloc = '0;
      end
   end

   // Controller: next state, RAM writes and response capture.
   always_comb begin
      state_in     = state_ff;
      type_in      = type_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      max_in       = max_ff;
      idx_in       = idx_ff;
      s_in         = s_ff;
      e_in         = e_ff;
      clr_in       = clr_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_ok_in    = rsp_ok_ff;
      rsp_page_in  = rsp_page_ff;
      wr_en        = 1'b0;
      wr_addr      = word_addr;
      wr_data      = rd_data | mask;

      case (state_ff)
         // Mark every page used, one word a cycle.
         pba_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '1;
            if (clr_ff == AW'(NUM_WORDS - 1)) begin
               state_in = pba_pkg::ST_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end

         // Capture a new transaction.
         pba_pkg::ST_IDLE: begin
            if (start) begin
               type_in  = req_type;
               count_in = req_page_count;
               step_in  = (req_step_pages == '0) ? COUNT_W'(1) : req_step_pages;
               if ((req_limit_page != '0) && (req_limit_page < cov)) begin
                  max_in = req_limit_page;
               end else begin
                  max_in = cov;
               end
               idx_in = POS_W'(base_ff);
               s_in   = POS_W'(req_page_index);
               e_in   = free_end;
               if (req_type == pba_pkg::REQ_FREE) begin
                  state_in = pba_pkg::ST_FREE_INIT;
               end else begin
                  state_in = pba_pkg::ST_ALLOC_INIT;
               end
            end
         end

         // Judge the current candidate start page against the bounds.
         pba_pkg::ST_ALLOC_INIT: begin
            if (idx_ff >= POS_W'(max_ff)) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b0;
               rsp_page_in  = '0;
               state_in     = pba_pkg::ST_IDLE;
            end else if ((idx_ff + POS_W'(count_ff)) > POS_W'(cov)) begin
               idx_in = idx_step;
            end else if (count_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               rsp_page_in  = PAGE_W'(idx_ff);
               if (track_ff) begin
                  cnt_in = cnt_alloc;
               end
               state_in = pba_pkg::ST_IDLE;
            end else begin
               s_in     = idx_ff;
               e_in     = idx_ff + POS_W'(count_ff);
               state_in = pba_pkg::ST_CHK_RD;
            end
         end

         // Wait for the word of the run under test.
         pba_pkg::ST_CHK_RD: begin
            state_in = pba_pkg::ST_CHK_EVAL;
         end

         // Any used page in the run rejects the candidate.
         pba_pkg::ST_CHK_EVAL: begin
            if (word_busy) begin
               idx_in   = idx_step;
               state_in = pba_pkg::ST_ALLOC_INIT;
            end else if (word_last) begin
               s_in     = idx_ff;
               state_in = pba_pkg::ST_SET_RD;
            end else begin
               s_in     = next_s;
               state_in = pba_pkg::ST_CHK_RD;
            end
         end

         // An empty free run goes straight to the response.
         pba_pkg::ST_FREE_INIT: begin
            if (s_ff >= e_ff) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               rsp_page_in  = '0;
               cnt_in       = cnt_free;
               state_in     = pba_pkg::ST_IDLE;
            end else begin
               state_in = pba_pkg::ST_SET_RD;
            end
         end

         // Wait for the word to be modified.
         pba_pkg::ST_SET_RD: begin
            state_in = pba_pkg::ST_SET_WR;
         end

         // Write the word back with the run set or cleared.
         pba_pkg::ST_SET_WR: begin
            wr_en = 1'b1;
            if (type_ff == pba_pkg::REQ_ALLOC) begin
               wr_data = rd_data | mask;
            end else begin
               wr_data = rd_data & ~mask;
            end
            if (word_last) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               if (type_ff == pba_pkg::REQ_ALLOC) begin
                  rsp_page_in = PAGE_W'(idx_ff);
                  if (track_ff) begin
                     cnt_in = cnt_alloc;
                  end
               end else begin
                  rsp_page_in = '0;
                  cnt_in      = cnt_free;
               end
               state_in = pba_pkg::ST_IDLE;
            end else begin
               s_in     = next_s;
               state_in = pba_pkg::ST_SET_RD;
            end
         end

         default: begin
            state_in = pba_pkg::ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pba_pkg::ST_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Transaction and response payload registers.
   always_ff @(posedge clock) begin
      type_ff     <= type_in;
      count_ff    <= count_in;
      step_ff     <= step_in;
      max_ff      <= max_in;
      idx_ff      <= idx_in;
      s_ff        <= s_in;
      e_ff        <= e_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_page_ff <= rsp_page_in;
   end

   // Bitmap storage, read continuously at the current word.
   pba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (NUM_WORDS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (word_addr),
      .rd_data (rd_data)
   );

   // Port drive.
   assign busy            = (state_ff != pba_pkg::ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_result_page = rsp_page_ff;
   assign rsp_free_count  = COUNT_W'(cnt_ff);

endmodule

`default_nettype wire

[rtl/core/pba_checker.sv]
// ----------------------------------------------------------------------------
// Page bitmap allocator port checker
// Concurrent assertions on the top-level ports, attached by a bind.
// ----------------------------------------------------------------------------
`default_nettype none

module pba_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            start,
   input wire logic                            busy,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ok,
   input wire logic [pba_pkg::PAGE_W-1:0]      rsp_result_page
);

   // An accepted transaction keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted transaction");

   // A response is shown only once the block is ready again.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while busy");

   // One transaction gives one single-cycle response.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   // A failed search reports page zero.
   a_fail_page: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_result_page == '0))
      else $error("failed allocation reports a nonzero page");

endmodule

bind page_bitmap_allocator pba_checker u_pba_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_ok          (rsp_ok),
   .rsp_result_page (rsp_result_page)
);

`default_nettype wire
